[src/kcs_pkg.sv]
// Shared types and constants for the tape byte encoder.
// No dependencies; every other module of the block imports this package.
`timescale 1ns / 1ps

package kcs_pkg;

  // Source clock of the duration registers and rounding offset
  localparam int unsigned SRC_CLOCK_HZ = 3500000;
  localparam int unsigned SRC_HALF     = SRC_CLOCK_HZ / 2;
  localparam int          SRC_W        = $clog2(SRC_CLOCK_HZ + 1);

  localparam int TICK_W = 16;
  localparam int DUR_W  = 32;
  localparam int CNT_W  = 16;

  // Scaled reciprocal of the source clock: quotient estimate is
  // ((y >> RCP_SHIFT) * SRC_RCP) >> RCP_FRAC, never above the true quotient
  localparam int                  RCP_SHIFT = 21;
  localparam int                  RCP_FRAC  = 24;
  localparam logic [63:0]         RCP_FULL  = (64'd1 << (RCP_SHIFT + RCP_FRAC)) /
                                              64'(SRC_CLOCK_HZ);
  localparam logic [RCP_FRAC-1:0] SRC_RCP   = RCP_FULL[RCP_FRAC-1:0];

  // Register indexes on the configuration port
  localparam logic [2:0] REG_PILOT_LEN  = 3'd0;
  localparam logic [2:0] REG_PILOT_CNT  = 3'd1;
  localparam logic [2:0] REG_ZERO_LEN   = 3'd2;
  localparam logic [2:0] REG_ONE_LEN    = 3'd3;
  localparam logic [2:0] REG_BIT_SETUP  = 3'd4;
  localparam logic [2:0] REG_BYTE_SETUP = 3'd5;
  localparam logic [2:0] REG_PAUSE_MS   = 3'd6;

  // Request codes on the input tuser
  localparam logic [1:0] REQ_LEAD  = 2'd0;
  localparam logic [1:0] REQ_BYTE  = 2'd1;
  localparam logic [1:0] REQ_PAUSE = 2'd2;

  // Result kinds on the output tuser
  localparam logic [1:0] KIND_RUN = 2'd0;
  localparam logic [1:0] KIND_SIL = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  // byte_setup bit positions
  localparam int BS_MSB_FIRST = 0;
  localparam int BS_RESERVED  = 1;
  localparam int BS_STOP_VAL  = 2;
  localparam int BS_START_VAL = 5;

  localparam int OUT_DATA_W = CNT_W + DUR_W;

  // Work class of a queued item
  typedef enum logic [1:0] {
    CLS_LEAD  = 2'd0,
    CLS_BYTE  = 2'd1,
    CLS_PAUSE = 2'd2,
    CLS_ERR   = 2'd3
  } cls_t;

  typedef struct packed {
    cls_t        cls;
    logic [7:0]  data;
  } q_ent_t;

  // Configuration as seen by the front and back parts
  typedef struct packed {
    logic [CNT_W-1:0] pilot_count;
    logic [7:0]       bit_setup;
    logic [7:0]       byte_setup;
    logic [15:0]      pause_ms;
    logic [DUR_W-1:0] pilot_dur;
    logic [DUR_W-1:0] zero_dur;
    logic [DUR_W-1:0] one_dur;
    logic             busy;
  } cfg_view_t;

endpackage

[src/kcs_cfg.sv]
// Configuration registers and the shared duration rescaler (constant multiply,
// reciprocal quotient estimate, one correction step). Depends on kcs_pkg.
`timescale 1ns / 1ps

module kcs_cfg import kcs_pkg::*; #(
  parameter int unsigned TARGET_CLOCK_HZ = 3579545
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  output cfg_view_t        view
);

  // target = A * source + B, so (ticks * target + half) / source
  // = ticks * A + (ticks * B + half) / source, and the second quotient fits 16 bits
  localparam int unsigned RS_A   = TARGET_CLOCK_HZ / SRC_CLOCK_HZ;
  localparam int unsigned RS_B   = TARGET_CLOCK_HZ % SRC_CLOCK_HZ;
  localparam int          A_W    = 5;
  localparam int          BASE_W = TICK_W + A_W;
  localparam int          Y_W    = TICK_W + SRC_W;
  localparam int          YT_W   = Y_W - RCP_SHIFT;
  localparam int          PROD_W = YT_W + RCP_FRAC;
  localparam int          REM_W  = SRC_W + 1;

  typedef enum logic [4:0] {
    RS_IDLE = 5'b00001,
    RS_MUL  = 5'b00010,
    RS_EST  = 5'b00100,
    RS_REM  = 5'b01000,
    RS_FIX  = 5'b10000
  } rs_state_t;

  logic [15:0] pilot_len_r, pilot_cnt_r, zero_len_r, one_len_r, pause_r;
  logic [7:0]  bit_setup_r, byte_setup_r;
  logic [DUR_W-1:0] dur_r [3];

  rs_state_t         state_r, state_nxt;
  logic [1:0]        sel_r, sel_nxt;
  logic [Y_W-1:0]    y_r, y_nxt;
  logic [BASE_W-1:0] base_r, base_nxt;
  logic [YT_W-1:0]   est_r, est_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;

  logic              wr;
  logic              restart;
  logic [15:0]       ticks;
  logic [PROD_W-1:0] est_prod;
  logic [Y_W-1:0]    est_back;
  logic              store;
  logic [DUR_W-1:0]  q_val;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;
  assign restart   = wr && (cfg_index == REG_PILOT_LEN || cfg_index == REG_ZERO_LEN ||
                            cfg_index == REG_ONE_LEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pilot_len_r  <= '0;
      pilot_cnt_r  <= '0;
      zero_len_r   <= '0;
      one_len_r    <= '0;
      bit_setup_r  <= '0;
      byte_setup_r <= '0;
      pause_r      <= '0;
    end else if (wr) begin
      case (cfg_index)
        REG_PILOT_LEN:  pilot_len_r  <= cfg_data;
        REG_PILOT_CNT:  pilot_cnt_r  <= cfg_data;
        REG_ZERO_LEN:   zero_len_r   <= cfg_data;
        REG_ONE_LEN:    one_len_r    <= cfg_data;
        REG_BIT_SETUP:  bit_setup_r  <= cfg_data[7:0];
        REG_BYTE_SETUP: byte_setup_r <= cfg_data[7:0];
        REG_PAUSE_MS:   pause_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel_r)
      2'd1:    ticks = zero_len_r;
      2'd2:    ticks = one_len_r;
      default: ticks = pilot_len_r;
    endcase
  end

  // Estimate is at most one below the true quotient; the remainder fixes it
  assign est_prod = PROD_W'(y_r[Y_W-1:RCP_SHIFT]) * PROD_W'(SRC_RCP);
  assign est_back = Y_W'(est_r) * Y_W'(SRC_CLOCK_HZ);
  // cannot pass 32 bits for target clocks up to 100 MHz
  assign q_val    = DUR_W'(base_r) + DUR_W'(est_r) +
                    DUR_W'(rem_r >= REM_W'(SRC_CLOCK_HZ));

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    y_nxt     = y_r;
    base_nxt  = base_r;
    est_nxt   = est_r;
    rem_nxt   = rem_r;
    store     = 1'b0;
    case (state_r)
      RS_IDLE: ;
      RS_MUL: begin
        y_nxt     = Y_W'(ticks) * Y_W'(RS_B) + Y_W'(SRC_HALF);
        base_nxt  = BASE_W'(ticks) * BASE_W'(RS_A);
        state_nxt = RS_EST;
      end
      RS_EST: begin
        est_nxt   = est_prod[PROD_W-1:RCP_FRAC];
        state_nxt = RS_REM;
      end
      RS_REM: begin
        rem_nxt   = REM_W'(y_r - est_back);
        state_nxt = RS_FIX;
      end
      RS_FIX: begin
        store = 1'b1;
        if (sel_r == 2'd2) begin
          state_nxt = RS_IDLE;
        end else begin
          sel_nxt   = sel_r + 1'b1;
          state_nxt = RS_MUL;
        end
      end
      default: state_nxt = RS_IDLE;
    endcase
    if (restart) begin
      sel_nxt   = 2'd0;
      state_nxt = RS_MUL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RS_IDLE;
      sel_r   <= '0;
      dur_r   <= '{default: '0};
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      if (store && !restart) begin
        dur_r[sel_r] <= q_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    y_r    <= y_nxt;
    base_r <= base_nxt;
    est_r  <= est_nxt;
    rem_r  <= rem_nxt;
  end

  assign view.pilot_count = pilot_cnt_r;
  assign view.bit_setup   = bit_setup_r;
  assign view.byte_setup  = byte_setup_r;
  assign view.pause_ms    = pause_r;
  assign view.pilot_dur   = dur_r[0];
  assign view.zero_dur    = dur_r[1];
  assign view.one_dur     = dur_r[2];
  assign view.busy        = (state_r != RS_IDLE);

endmodule

[src/kcs_front.sv]
// Input side: accept beats, classify them and push work into the queue.
// Depends on kcs_pkg.
`timescale 1ns / 1ps

module kcs_front import kcs_pkg::*; (
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic [1:0] in_tuser,
  input  cfg_view_t  view,
  input  logic       q_full,
  output logic       q_push,
  output q_ent_t     q_wdata
);

  logic acc;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    q_wdata.data = in_tdata;
    q_wdata.cls  = CLS_LEAD;
    q_push       = acc;
    if (view.byte_setup[BS_RESERVED]) begin
      q_wdata.cls = CLS_ERR;
    end else begin
      case (in_tuser)
        REQ_LEAD:  q_wdata.cls = CLS_LEAD;
        REQ_BYTE:  q_wdata.cls = CLS_BYTE;
        REQ_PAUSE: q_wdata.cls = CLS_PAUSE;
        default:   q_push      = 1'b0; // unused code: drop
      endcase
    end
  end

endmodule

[src/kcs_fifo.sv]
// Short queue of classified work between the front and back parts.
// Depends on kcs_pkg.
`timescale 1ns / 1ps

module kcs_fifo import kcs_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  q_ent_t wdata,
  output logic   full,
  input  logic   pop,
  output logic   rvalid,
  output q_ent_t rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_ent_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign rvalid  = (cnt_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && rvalid;
  assign rdata   = mem[rd_ptr_r];

  function automatic logic [PTR_W-1:0] inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= inc(rd_ptr_r);
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= wdata;
  end

endmodule

[src/kcs_back.sv]
// Output side: step through the bit runs of each queued item and drive the
// registered result channel. Depends on kcs_pkg.
`timescale 1ns / 1ps

module kcs_back import kcs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_view_t             view,
  input  logic                  q_vld,
  input  q_ent_t                q_rdata,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]            out_tuser,
  output logic                  out_tlast
);

  logic       cur_vld_r, cur_vld_nxt;
  q_ent_t     cur_r;
  logic [3:0] step_r, step_nxt;

  logic                  out_vld_r, out_vld_nxt;
  logic [1:0]            kind_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DUR_W-1:0]      dur_r;
  logic                  last_r;

  logic [1:0]       starts, stops;
  logic [3:0]       total, idx;
  logic [2:0]       pos;
  logic             bit_one, emit, res_last;
  logic [4:0]       zp, op;
  logic [1:0]       res_kind;
  logic [CNT_W-1:0] res_cnt;
  logic [DUR_W-1:0] res_dur;

  assign starts = view.byte_setup[7:6];
  assign stops  = view.byte_setup[4:3];
  assign total  = 4'd8 + 4'(starts) + 4'(stops);
  assign idx    = step_r - 4'(starts);
  assign pos    = view.byte_setup[BS_MSB_FIRST] ? 3'd7 - idx[2:0] : idx[2:0];
  assign zp     = (view.bit_setup[7:4] == 4'd0) ? 5'd16 : {1'b0, view.bit_setup[7:4]};
  assign op     = (view.bit_setup[3:0] == 4'd0) ? 5'd16 : {1'b0, view.bit_setup[3:0]};

  always_comb begin
    if (step_r < 4'(starts))            bit_one = view.byte_setup[BS_START_VAL];
    else if (step_r < 4'(starts) + 4'd8) bit_one = cur_r.data[pos];
    else                                bit_one = view.byte_setup[BS_STOP_VAL];
  end

  always_comb begin
    res_kind = KIND_RUN;
    res_cnt  = '0;
    res_dur  = '0;
    res_last = 1'b1;
    case (cur_r.cls)
      CLS_LEAD: begin
        res_cnt = view.pilot_count;
        res_dur = view.pilot_dur;
      end
      CLS_BYTE: begin
        res_cnt  = CNT_W'(bit_one ? op : zp);
        res_dur  = bit_one ? view.one_dur : view.zero_dur;
        res_last = (step_r == total - 4'd1);
      end
      CLS_PAUSE: begin
        res_kind = KIND_SIL;
        res_dur  = DUR_W'(view.pause_ms);
      end
      CLS_ERR:  res_kind = KIND_ERR;
      default:  res_kind = KIND_ERR;
    endcase
  end

  // hold results while the rescaler refreshes the durations
  assign emit  = cur_vld_r && !view.busy && (!out_vld_r || out_tready);
  assign q_pop = q_vld && (!cur_vld_r || (emit && res_last));

  always_comb begin
    cur_vld_nxt = cur_vld_r;
    step_nxt    = step_r;
    if (q_pop) begin
      cur_vld_nxt = 1'b1;
      step_nxt    = '0;
    end else if (emit) begin
      step_nxt = step_r + 1'b1;
      if (res_last) cur_vld_nxt = 1'b0;
    end
    out_vld_nxt = emit ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      step_r    <= '0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      out_vld_r <= out_vld_nxt;
      step_r    <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_rdata;
    if (emit) begin
      kind_r <= res_kind;
      cnt_r  <= res_cnt;
      dur_r  <= res_dur;
      last_r <= res_last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {dur_r, cnt_r};
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

endmodule

[src/kcs_tape_byte_encoder.sv]
// Top level of the tape byte encoder: front classifier, work queue, back
// sequencer and configuration/rescaler. Depends on kcs_pkg and all kcs_* modules.
//
//   channel | direction | beat carries
//   --------+-----------+-------------------------------------------------
//   in_     | slave     | tuser = request type, tdata = data byte
//   out_    | master    | tuser = kind, tdata = {duration, pulse_count},
//           |           | tlast = final result of the request
//   cfg_    | slave     | cfg_index = register, cfg_data = value
//
// A data byte gives start+8+stop result beats, one per cycle while out_tready stays
// high and the rescaler is idle; lead-in, pause and error requests give one beat
// each. A request's first beat passes the queue, current-item and output registers.
// Requests queue up to QUEUE_DEPTH deep, so input keeps flowing while output stalls
// until the queue fills. A duration register write restarts the rescaler, which
// holds results back. Synchronous reset covers config and control registers only.
`timescale 1ns / 1ps

module kcs_tape_byte_encoder import kcs_pkg::*; #(
  parameter int unsigned TARGET_CLOCK_HZ = 3579545,
  parameter int          QUEUE_DEPTH     = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input requests
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic [1:0]            in_tuser,   // [1:0] req_type
  // result runs
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [15:0] pulse_count, [47:16] duration
  output logic [1:0]            out_tuser,  // [1:0] kind
  output logic                  out_tlast,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data
);

  cfg_view_t view;
  q_ent_t    q_wdata, q_rdata;
  logic      q_push, q_full, q_pop, q_vld;

  kcs_cfg #(
    .TARGET_CLOCK_HZ (TARGET_CLOCK_HZ)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .view      (view)
  );

  // classify accepted beats; unused codes are dropped unless the reserved bit is set
  kcs_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .view      (view),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  kcs_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_vld),
    .rdata  (q_rdata)
  );

  // advance through the runs of the head item
  kcs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .view       (view),
    .q_vld      (q_vld),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[src/kcs_checker.sv]
// Port-level checks for the tape byte encoder, bound to its top level.
// Depends on kcs_pkg and kcs_tape_byte_encoder.
`timescale 1ns / 1ps

module kcs_props import kcs_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [7:0]            in_tdata,
  input logic [1:0]            in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]            out_tuser,
  input logic                  out_tlast,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [2:0]            cfg_index,
  input logic [15:0]           cfg_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat dropped or changed while stalled");

  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_ERR |-> out_tlast && out_tdata == '0)
    else $error("error beat not a single zero result");

  a_sil_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_SIL |-> out_tlast && out_tdata[CNT_W-1:0] == '0)
    else $error("silence beat carries pulses or is not last");

  a_rst_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid straight after reset");

endmodule

bind kcs_tape_byte_encoder kcs_props u_kcs_props (.*);
